FILE: rtl/stx_etx_framer_block_xor_check_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the stx/etx framer core
// shared by the checker that watches the core's ports
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAMER_BLOCK_XOR_CHECK_CORE_DEFINES_SVH
`define STX_ETX_FRAMER_BLOCK_XOR_CHECK_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SEFX_ASSERT_NOW(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, disabled while reset is held
`define SEFX_ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
        else $error("framer check failed");

`endif

FILE: rtl/sefx_pkg.sv
// ----------------------------------------------------------------------------
// sefx_pkg
// shared types and codes of the stx/etx framer with block xor check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sefx_pkg;

    // byte kind codes carried on m_tuser
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CHECK   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_START_CODE = 2'd0;
    localparam logic [1:0] REG_END_CODE   = 2'd1;
    localparam logic [1:0] REG_PAD_VALUE  = 2'd2;

    localparam logic [7:0] START_CODE_RST = 8'h02;
    localparam logic [7:0] END_CODE_RST   = 8'h03;
    localparam logic [7:0] PAD_VALUE_RST  = 8'hFF;

    // what the accumulator tells the emitter about an accepted beat
    typedef struct packed {
        logic       opening;
        logic       closing;
        logic [7:0] payload;
    } sefx_step_t;

endpackage

`default_nettype wire

FILE: rtl/sefx_accum.sv
// ----------------------------------------------------------------------------
// sefx_accum
// frame state and block xor accumulator, updated once per accepted beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sefx_accum #(
    parameter int CHECK_BYTES = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_accept,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_last,
    input  wire logic [7:0]                 pad_value,
    output sefx_pkg::sefx_step_t            step,
    output logic      [CHECK_BYTES*8-1:0]   trailer
);

    localparam int POS_W = (CHECK_BYTES > 1) ? $clog2(CHECK_BYTES) : 1;

    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     in_frame_reg, in_frame_next;
    logic [CHECK_BYTES*8-1:0] accum_reg, accum_next;
    logic [CHECK_BYTES*8-1:0] accum_upd;
    logic                     closing;

    // the flag is ignored on the byte that opens a frame
    assign closing = in_last && in_frame_reg;

    assign step.opening = !in_frame_reg;
    assign step.closing = closing;
    assign step.payload = in_byte;

    // positions past the current one are padded when a frame closes
    for (genvar i = 0; i < CHECK_BYTES; i++) begin : g_lane
        always_comb begin
            accum_upd[i*8 +: 8] = accum_reg[i*8 +: 8];
            if (pos_reg == POS_W'(i)) begin
                accum_upd[i*8 +: 8] = accum_upd[i*8 +: 8] ^ in_byte;
            end
            if (closing && (POS_W'(i) > pos_reg)) begin
                accum_upd[i*8 +: 8] = accum_upd[i*8 +: 8] ^ pad_value;
            end
        end
    end

    assign trailer = accum_upd;

    always_comb begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        accum_next    = accum_reg;
        if (in_accept) begin
            if (closing) begin
                pos_next      = '0;
                in_frame_next = 1'b0;
                accum_next    = '0;
            end else begin
                in_frame_next = 1'b1;
                accum_next    = accum_upd;
                if (pos_reg == POS_W'(CHECK_BYTES - 1)) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            accum_reg    <= '0;
        end else begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            accum_reg    <= accum_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sefx_emitter.sv
// ----------------------------------------------------------------------------
// sefx_emitter
// output register that plays out the beats caused by one accepted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sefx_emitter #(
    parameter int CHECK_BYTES = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_accept,
    input  wire sefx_pkg::sefx_step_t       step,
    input  wire logic [CHECK_BYTES*8-1:0]   trailer,
    input  wire logic [7:0]                 start_code,
    input  wire logic [7:0]                 end_code,
    output logic                            free,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,
    output logic      [1:0]                 m_tuser,
    output logic                            m_tlast
);

    localparam int CNT_W = (CHECK_BYTES > 1) ? $clog2(CHECK_BYTES) : 1;

    // the phase is the kind of the beat on the output
    localparam logic [1:0] PH_START   = sefx_pkg::KIND_START;
    localparam logic [1:0] PH_PAYLOAD = sefx_pkg::KIND_PAYLOAD;
    localparam logic [1:0] PH_CHECK   = sefx_pkg::KIND_CHECK;
    localparam logic [1:0] PH_END     = sefx_pkg::KIND_END;

    logic                     valid_reg, valid_next;
    logic [1:0]               phase_reg, phase_next;
    logic [7:0]               data_reg, data_next;
    logic                     last_reg, last_next;
    logic                     close_reg, close_next;
    logic [7:0]               held_reg, held_next;
    logic [7:0]               end_reg, end_next;
    logic [CHECK_BYTES*8-1:0] trailer_reg, trailer_next;
    logic [CHECK_BYTES*8-1:0] shifted;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     beat;

    assign beat    = valid_reg && m_tready;
    assign free    = !valid_reg || (last_reg && m_tready);
    assign shifted = trailer_reg >> 8;

    always_comb begin
        valid_next   = valid_reg;
        phase_next   = phase_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        close_next   = close_reg;
        held_next    = held_reg;
        end_next     = end_reg;
        trailer_next = trailer_reg;
        cnt_next     = cnt_reg;

        if (beat) begin
            case (phase_reg)
                PH_START: begin
                    phase_next = PH_PAYLOAD;
                    data_next  = held_reg;
                    last_next  = 1'b1;
                end
                PH_PAYLOAD: begin
                    if (close_reg) begin
                        phase_next = PH_CHECK;
                        data_next  = trailer_reg[7:0];
                        last_next  = 1'b0;
                        cnt_next   = '0;
                    end else begin
                        valid_next = 1'b0;
                    end
                end
                PH_CHECK: begin
                    if (cnt_reg == CNT_W'(CHECK_BYTES - 1)) begin
                        phase_next = PH_END;
                        data_next  = end_reg;
                        last_next  = 1'b1;
                    end else begin
                        data_next    = shifted[7:0];
                        trailer_next = shifted;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end
                end
                default: begin
                    valid_next = 1'b0;
                    close_next = 1'b0;
                end
            endcase
        end

        // a new byte loads once the last beat of the previous one leaves
        if (in_accept) begin
            valid_next = 1'b1;
            close_next = step.closing;
            if (step.opening) begin
                phase_next = PH_START;
                data_next  = start_code;
                last_next  = 1'b0;
                held_next  = step.payload;
            end else begin
                phase_next   = PH_PAYLOAD;
                data_next    = step.payload;
                last_next    = !step.closing;
                trailer_next = trailer;
                end_next     = end_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= PH_START;
            last_reg  <= 1'b0;
            close_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            close_reg <= close_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg    <= data_next;
        held_reg    <= held_next;
        end_reg     <= end_next;
        trailer_reg <= trailer_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = phase_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/stx_etx_framer_block_xor_check_core.sv
// ----------------------------------------------------------------------------
// stx_etx_framer_block_xor_check_core
// frames payload bytes with start/end delimiters and a block xor check
// ----------------------------------------------------------------------------
// output: registered, so the first beat shows in the cycle after acceptance
// pacing: the single output register plays each beat; the opening byte
//   adds a start delimiter, the closing byte the check bytes and the
//   end delimiter; a new byte waits for the last beat of the one before
// reset: synchronous active-low aresetn clears the frame state, the check
//   bytes and the output, and restores the delimiter and pad registers
`timescale 1ns / 1ps
`default_nettype none

module stx_etx_framer_block_xor_check_core #(
    parameter int CHECK_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // payload in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  wire logic        s_tlast,   // payload_last
    // frame out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] frame_byte
    output logic      [1:0]  m_tuser,   // [1:0] byte_kind
    output logic             m_tlast    // run_last
);

    logic [7:0]               start_code_reg, start_code_next;
    logic [7:0]               end_code_reg, end_code_next;
    logic [7:0]               pad_value_reg, pad_value_next;
    logic                     cfg_write;
    logic [1:0]               cfg_index;
    logic                     in_accept;
    logic                     free;
    sefx_pkg::sefx_step_t     step;
    logic [CHECK_BYTES*8-1:0] trailer;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb begin
        start_code_next = start_code_reg;
        end_code_next   = end_code_reg;
        pad_value_next  = pad_value_reg;
        if (cfg_write) begin
            case (cfg_index)
                sefx_pkg::REG_START_CODE: start_code_next = pwdata[7:0];
                sefx_pkg::REG_END_CODE:   end_code_next   = pwdata[7:0];
                sefx_pkg::REG_PAD_VALUE:  pad_value_next  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            sefx_pkg::REG_START_CODE: prdata = {24'd0, start_code_reg};
            sefx_pkg::REG_END_CODE:   prdata = {24'd0, end_code_reg};
            sefx_pkg::REG_PAD_VALUE:  prdata = {24'd0, pad_value_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg <= sefx_pkg::START_CODE_RST;
            end_code_reg   <= sefx_pkg::END_CODE_RST;
            pad_value_reg  <= sefx_pkg::PAD_VALUE_RST;
        end else begin
            start_code_reg <= start_code_next;
            end_code_reg   <= end_code_next;
            pad_value_reg  <= pad_value_next;
        end
    end

    assign s_tready  = free;
    assign in_accept = s_tvalid && s_tready;

    sefx_accum #(
        .CHECK_BYTES (CHECK_BYTES)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .pad_value (pad_value_reg),
        .step      (step),
        .trailer   (trailer)
    );

    sefx_emitter #(
        .CHECK_BYTES (CHECK_BYTES)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .step       (step),
        .trailer    (trailer),
        .start_code (start_code_reg),
        .end_code   (end_code_reg),
        .free       (free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/sefx_checker.sv
// ----------------------------------------------------------------------------
// sefx_checker
// port-level checks of the framer core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stx_etx_framer_block_xor_check_core_defines.svh"

module sefx_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // a stalled output beat holds
    `SEFX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // input is only taken when the output is empty or its final beat leaves
    `SEFX_ASSERT_NOW(a_ready_free, aclk, aresetn, s_tready, !m_tvalid || (m_tlast && m_tready))

    // the end delimiter always closes the run, the start delimiter never does
    `SEFX_ASSERT_NOW(a_end_last, aclk, aresetn, m_tvalid && (m_tuser == sefx_pkg::KIND_END), m_tlast)
    `SEFX_ASSERT_NOW(a_start_not_last, aclk, aresetn, m_tvalid && (m_tuser == sefx_pkg::KIND_START), !m_tlast)

    // a start delimiter is followed directly by its payload byte
    `SEFX_ASSERT_NEXT(a_start_then_payload, aclk, aresetn, m_tvalid && m_tready && (m_tuser == sefx_pkg::KIND_START), m_tvalid && (m_tuser == sefx_pkg::KIND_PAYLOAD))

endmodule

bind stx_etx_framer_block_xor_check_core sefx_checker u_sefx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/stx_etx_framer_block_xor_check_core_tb.sv
// ----------------------------------------------------------------------------
// stx_etx_framer_block_xor_check_core_tb
// self-checking bench for the stx/etx framer: a directed table of payload
// beats, then random frames under several delimiter and pad settings, with
// random stalls on both streams; each output beat is checked against the
// typed rows or a cycle-free model of the framing and the block xor check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stx_etx_framer_block_xor_check_core_tb;

    import sefx_pkg::*;

    localparam int CHECK_N        = 8;
    localparam int MAX_BEATS      = CHECK_N + 2;
    localparam int DIR_N          = 23;
    localparam int PHASE_ITEMS    = 28;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 200000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] fbyte;
        logic [1:0] kind;
        logic       last;
    } frame_beat_t;

    // one row of the directed table; typed rows carry their own results
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       opens;
        logic [7:0] lead;
        logic       cfg_next;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] payload_byte
    logic        s_tlast;   // payload_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] frame_byte
    logic [1:0]  m_tuser;   // [1:0] byte_kind
    logic        m_tlast;   // run_last

    stx_etx_framer_block_xor_check_core #(
        .CHECK_BYTES(CHECK_N)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // framer state as the bench sees it
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    logic [7:0]  cfg_pad;
    logic [7:0]  xor_acc [CHECK_N];
    int          blk_pos;
    logic        frame_open;

    frame_beat_t pending_beats [$];
    frame_beat_t step_beats [MAX_BEATS];
    int          step_count;

    int          err_count  = 0;
    int          cycle_cnt  = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_asks  = 0;

    dir_row_t    dir_rows [DIR_N];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver pacing, with a long hold-off whenever one is asked for
    initial begin : rx_pace
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on) begin
                m_tready <= ($urandom_range(99) >= 31);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: frame_byte %02h byte_kind %0d run_last %0b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata !== want.fbyte) begin
                    $error("frame_byte mismatch: expected %02h, actual %02h",
                           want.fbyte, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.kind) begin
                    $error("byte_kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("run_last mismatch: expected %0b, actual %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    function automatic void framer_reset();
        cfg_start  = START_CODE_RST;
        cfg_end    = END_CODE_RST;
        cfg_pad    = PAD_VALUE_RST;
        blk_pos    = 0;
        frame_open = 1'b0;
        for (int i = 0; i < CHECK_N; i++) xor_acc[i] = 8'h00;
    endfunction

    function automatic void add_beat(logic [7:0] b, logic [1:0] k, logic l);
        step_beats[step_count] = '{fbyte: b, kind: k, last: l};
        step_count++;
    endfunction

    // output beats caused by one payload beat, into step_beats
    function automatic void frame_beats_for(logic [7:0] data, logic last);
        logic closing;
        step_count = 0;
        // a last flag on the byte that opens a frame does not close it
        closing = last && frame_open;
        if (!frame_open) begin
            add_beat(cfg_start, KIND_START, 1'b0);
            frame_open = 1'b1;
        end
        add_beat(data, KIND_PAYLOAD, !closing);
        xor_acc[blk_pos] = xor_acc[blk_pos] ^ data;
        blk_pos = (blk_pos + 1) % CHECK_N;
        if (closing) begin
            if (blk_pos != 0) begin
                for (int i = blk_pos; i < CHECK_N; i++) xor_acc[i] = xor_acc[i] ^ cfg_pad;
            end
            for (int i = 0; i < CHECK_N; i++) add_beat(xor_acc[i], KIND_CHECK, 1'b0);
            add_beat(cfg_end, KIND_END, 1'b1);
            for (int i = 0; i < CHECK_N; i++) xor_acc[i] = 8'h00;
            blk_pos    = 0;
            frame_open = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                             input logic opens, input logic [7:0] lead);
        while (tx_idle_on && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        frame_beats_for(data, last);
        if (typed) begin
            if (opens) pending_beats.push_back('{fbyte: lead, kind: KIND_START, last: 1'b0});
            pending_beats.push_back('{fbyte: data, kind: KIND_PAYLOAD, last: 1'b1});
        end else begin
            for (int i = 0; i < step_count; i++) pending_beats.push_back(step_beats[i]);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        // the core emits in the cycle after acceptance; leave a little margin
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        logic [23:0] junk;
        junk = 24'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_START_CODE: cfg_start = val;
            REG_END_CODE:   cfg_end   = val;
            REG_PAD_VALUE:  cfg_pad   = val;
            default: ;
        endcase
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [7:0] want, input string name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {24'h000000, want}) begin
            $error("%s mismatch: expected %08h, actual %08h", name, {24'h000000, want}, prdata);
            err_count++;
        end
    endtask

    task automatic regs_check();
        reg_check(REG_START_CODE, cfg_start, "start_code");
        reg_check(REG_END_CODE, cfg_end, "end_code");
        reg_check(REG_PAD_VALUE, cfg_pad, "pad_value");
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_framing(input logic [7:0] st, input logic [7:0] en, input logic [7:0] pd);
        drain();
        reg_write(REG_START_CODE, st);
        reg_write(REG_END_CODE, en);
        reg_write(REG_PAD_VALUE, pd);
        // an address past the register list must leave everything alone
        reg_write(REG_UNUSED, 8'($urandom));
        regs_check();
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int         cfg_idx;
        int         sent;
        int         len;
        logic       last;
        logic [7:0] dir_cfg [2][3];

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        framer_reset();

        // data, last, typed, opens, lead, cfg_next
        // last flag on the opening byte is ignored, 3-byte frame gets padded
        dir_rows[0]  = '{8'h00, 1'b1, 1'b1, 1'b1, 8'h02, 1'b0};
        dir_rows[1]  = '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[2]  = '{8'hA5, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
        // one full block, walking ones, no padding
        dir_rows[3]  = '{8'h01, 1'b0, 1'b1, 1'b1, 8'h02, 1'b0};
        dir_rows[4]  = '{8'h02, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[5]  = '{8'h04, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[6]  = '{8'h08, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[7]  = '{8'h10, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[8]  = '{8'h20, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[9]  = '{8'h40, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[10] = '{8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
        // shortest frame with zero start delimiter, all-ones end delimiter and zero pad
        dir_rows[11] = '{8'h5A, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1};
        dir_rows[12] = '{8'hC3, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
        // ten bytes: wraps into a second, partial block
        dir_rows[13] = '{8'h11, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1};
        dir_rows[14] = '{8'h22, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[15] = '{8'h33, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[16] = '{8'h44, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[17] = '{8'h55, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[18] = '{8'h66, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[19] = '{8'h77, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[20] = '{8'h88, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[21] = '{8'h99, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
        dir_rows[22] = '{8'hAA, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

        // start, end, pad
        dir_cfg[0] = '{8'h00, 8'hFF, 8'h00};
        dir_cfg[1] = '{8'hFF, 8'h00, 8'h55};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        regs_check();
        @(posedge aclk);

        cfg_idx = 0;
        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].cfg_next) begin
                set_framing(dir_cfg[cfg_idx][0], dir_cfg[cfg_idx][1], dir_cfg[cfg_idx][2]);
                cfg_idx++;
            end
            send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                      dir_rows[r].opens, dir_rows[r].lead);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       set_framing(8'h00, 8'h00, 8'h00);
                2:       set_framing(8'hFF, 8'hFF, 8'hFF);
                default: set_framing(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            // phase 1 runs with both streams at full rate
            tx_idle_on = (ph != 1);
            rx_idle_on = (ph != 1);
            // phase 2 opens with the receiver stalled while bytes keep coming
            if (ph == 2) hold_asks++;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(7) == 0) len = CHECK_N * $urandom_range(1, 3);
                else len = $urandom_range(2, 12);
                for (int k = 0; k < len; k++) begin
                    last = (k == len - 1) || (k == 0 && $urandom_range(9) == 0);
                    if (k > 0 && $urandom_range(99) < 3) drain();
                    send_byte(8'($urandom), last, 1'b0, 1'b0, 8'h00);
                    sent++;
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
